// ===== rtl/sftrd_pkg.sv =====
package sftrd_pkg;

  localparam logic [7:0] TS_ID         = 8'hff;
  localparam logic [3:0] UNKNOWN_ENTRY = 4'd13;
  localparam logic [3:0] WRDI_ENTRY    = 4'd3;
  localparam logic [2:0] BYTES_PER_REC = 3'd6;
  localparam int         QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] OP_TABLE [14] = '{
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h0b,
    8'h11, 8'h3b, 8'h60, 8'h9f, 8'hc7, 8'hd8, 8'hff
  };
  localparam logic       OP_ADDR  [14] = '{
    1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0
  };
  localparam logic [1:0] OP_PAD   [14] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
  };

  typedef struct packed {
    logic [7:0]      record_id;
    logic [7:0]      record_pos;
    logic [5:0][7:0] payload;
  } rec_t;

  typedef struct packed {
    logic            has_hdr;
    logic [7:0]      opcode;
    logic [3:0]      entry;
    logic [31:0]     cmd_num;
    logic [47:0]     elapsed;
    logic [23:0]     addr;
    logic [2:0]      j_start;
    logic [2:0]      j_end;
    logic [5:0][7:0] bytes;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] command_number;
    logic [7:0]  opcode;
    logic [3:0]  table_index;
    logic [47:0] elapsed_time;
    logic        has_address;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
    logic [3:0]  column;
    logic        last;
  } res_t;

  function automatic logic [3:0] lookup_entry(input logic [7:0] op);
    logic [3:0] e;
    e = UNKNOWN_ENTRY;
    for (int k = 12; k >= 0; k--) begin
      if (OP_TABLE[k] == op) e = 4'(k);
    end
    return e;
  endfunction

endpackage

// ===== rtl/sftrd_in_if.sv =====
interface sftrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_id;
  logic [7:0] record_pos;
  logic [7:0] payload_0;
  logic [7:0] payload_1;
  logic [7:0] payload_2;
  logic [7:0] payload_3;
  logic [7:0] payload_4;
  logic [7:0] payload_5;

  modport source (
    output valid, record_id, record_pos,
           payload_0, payload_1, payload_2, payload_3, payload_4, payload_5,
    input  ready
  );
  modport sink (
    input  valid, record_id, record_pos,
           payload_0, payload_1, payload_2, payload_3, payload_4, payload_5,
    output ready
  );
endinterface

// ===== rtl/sftrd_out_if.sv =====
interface sftrd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] command_number;
  logic [7:0]  opcode;
  logic [3:0]  table_index;
  logic [47:0] elapsed_time;
  logic        has_address;
  logic [31:0] byte_address;
  logic [7:0]  data_byte;
  logic [3:0]  column;
  logic        last;

  modport source (
    output valid, kind, command_number, opcode, table_index, elapsed_time,
           has_address, byte_address, data_byte, column, last,
    input  ready
  );
  modport sink (
    input  valid, kind, command_number, opcode, table_index, elapsed_time,
           has_address, byte_address, data_byte, column, last,
    output ready
  );
endinterface

// ===== rtl/sftrd_front.sv =====
module sftrd_front
  import sftrd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  rec_t in_rec,
  input  logic q_full,
  output logic q_push,
  output job_t q_job
);

  logic [7:0]  cur_id_r;
  logic [7:0]  pos_mark_r;
  logic [31:0] cmd_cnt_r;
  logic [47:0] last_ts_r;
  logic [47:0] start_ts_r;
  logic [3:0]  entry_r;
  logic [2:0]  pad_carry_r;

  logic        accept;
  logic        is_ts;
  logic        new_cmd;
  logic [3:0]  entry_nxt;
  logic        has_addr;
  logic [2:0]  skip;
  logic [2:0]  j0;
  logic [2:0]  pad_carry_nxt;
  logic [7:0]  mark;
  logic [7:0]  diff;
  logic [2:0]  blk_len;
  logic [31:0] cmd_cnt_nxt;
  logic [47:0] start_ts_nxt;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_ts     = (in_rec.record_id == TS_ID);
    new_cmd   = !is_ts && (in_rec.record_id != cur_id_r);
    entry_nxt = new_cmd ? lookup_entry(in_rec.payload[0]) : entry_r;
    has_addr  = OP_ADDR[entry_nxt];
    skip      = 3'd4 + {1'b0, OP_PAD[entry_nxt]};
    pad_carry_nxt = 3'd0;
    if (new_cmd) begin
      if (has_addr) begin
        if (skip > BYTES_PER_REC) begin
          j0            = BYTES_PER_REC;
          pad_carry_nxt = skip - BYTES_PER_REC;
        end else begin
          j0 = skip;
        end
      end else begin
        j0 = 3'd1;
      end
    end else begin
      j0 = pad_carry_r;
    end
    mark = new_cmd ? 8'd0 : pos_mark_r;
    diff = in_rec.record_pos - mark;
    // position delta is in eighths of a byte; clamp covers the over-read
    blk_len = (diff[7:3] > {2'b00, BYTES_PER_REC}) ? BYTES_PER_REC : diff[5:3];
    cmd_cnt_nxt  = new_cmd ? cmd_cnt_r + 32'd1 : cmd_cnt_r;
    start_ts_nxt = (new_cmd && cmd_cnt_r == 32'd0) ? last_ts_r : start_ts_r;
  end

  always_comb begin
    q_push        = accept && !is_ts && (new_cmd || (j0 < blk_len));
    q_job.has_hdr = new_cmd;
    q_job.opcode  = in_rec.payload[0];
    q_job.entry   = entry_nxt;
    q_job.cmd_num = cmd_cnt_nxt;
    q_job.elapsed = last_ts_r - start_ts_nxt;
    q_job.addr    = {in_rec.payload[1], in_rec.payload[2], in_rec.payload[3]};
    q_job.j_start = j0;
    q_job.j_end   = blk_len;
    q_job.bytes   = in_rec.payload;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_id_r    <= TS_ID;
      pos_mark_r  <= 8'd0;
      cmd_cnt_r   <= 32'd0;
      last_ts_r   <= 48'd0;
      start_ts_r  <= 48'd0;
      entry_r     <= WRDI_ENTRY;
      pad_carry_r <= 3'd0;
    end else if (accept) begin
      if (is_ts) begin
        last_ts_r   <= {in_rec.payload[0], in_rec.payload[1], in_rec.payload[2],
                        in_rec.payload[3], in_rec.payload[4], in_rec.payload[5]};
        pad_carry_r <= 3'd0;
      end else begin
        cur_id_r    <= in_rec.record_id;
        entry_r     <= entry_nxt;
        cmd_cnt_r   <= cmd_cnt_nxt;
        start_ts_r  <= start_ts_nxt;
        pad_carry_r <= pad_carry_nxt;
        pos_mark_r  <= in_rec.record_pos + 8'h10;
      end
    end
  end

endmodule

// ===== rtl/sftrd_queue.sv =====
module sftrd_queue
  import sftrd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t q_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/sftrd_back.sv =====
module sftrd_back
  import sftrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);

  logic [31:0] offset_r;
  logic        busy_r;
  job_t        job_r;
  logic [2:0]  j_r;
  logic        hdr_pend_r;
  logic [31:0] line_addr_r;
  logic [3:0]  line_col_r;
  logic        out_valid_r;
  res_t        out_r;

  logic        has_addr;
  logic        is_last;
  logic        fire;
  logic [31:0] addr_base;
  logic [3:0]  col_inc;
  res_t        res;

  always_comb begin
    has_addr  = OP_ADDR[job_r.entry];
    is_last   = hdr_pend_r ? (job_r.j_start >= job_r.j_end)
                           : (({1'b0, j_r} + 4'd1) >= {1'b0, job_r.j_end});
    fire      = busy_r && (!out_valid_r || out_ready);
    q_pop     = q_valid && (!busy_r || (fire && is_last));
    addr_base = hdr_pend_r ? {8'h00, job_r.addr} : line_addr_r + {28'h0, line_col_r};
    col_inc   = line_col_r + 4'd1;

    res.kind           = !hdr_pend_r;
    res.command_number = job_r.cmd_num;
    res.opcode         = hdr_pend_r ? job_r.opcode : OP_TABLE[job_r.entry];
    res.table_index    = job_r.entry;
    res.elapsed_time   = job_r.elapsed;
    res.has_address    = has_addr;
    res.byte_address   = has_addr ? offset_r + addr_base : 32'd0;
    res.data_byte      = hdr_pend_r ? 8'd0 : job_r.bytes[j_r];
    res.column         = hdr_pend_r ? 4'd0 : line_col_r;
    res.last           = is_last;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (fire) out_r <= res;
    if (busy_r && !hdr_pend_r && !fire) job_r <= job_r;
    if (q_pop) job_r <= q_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= 32'd0;
      busy_r      <= 1'b0;
      j_r         <= 3'd0;
      hdr_pend_r  <= 1'b0;
      line_addr_r <= 32'd0;
      line_col_r  <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) offset_r <= cfg_wdata;

      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (fire) begin
        if (hdr_pend_r) begin
          line_col_r <= 4'd0;
          if (has_addr) line_addr_r <= {8'h00, job_r.addr};
        end else begin
          line_col_r <= col_inc;
          // next 16-byte line
          if (col_inc == 4'd0 && has_addr) line_addr_r <= line_addr_r + 32'd16;
        end
      end

      if (q_pop) begin
        busy_r     <= 1'b1;
        j_r        <= q_job.j_start;
        hdr_pend_r <= q_job.has_hdr;
      end else if (fire) begin
        if (is_last) busy_r <= 1'b0;
        if (hdr_pend_r) hdr_pend_r <= 1'b0;
        else j_r <= j_r + 3'd1;
      end
    end
  end

endmodule

// ===== rtl/spi_flash_trace_record_decoder.sv =====
// The first result of a record passes through the queue, the back-end job register
// and the output register. Throughput: one result per cycle on the output while
// out_ready is high; a record yields header plus data bytes, up to 6 results.
// Records that yield nothing (timestamps, empty data) push nothing into the queue.
// Reset (rst_n low, synchronous) clears the queue, command state and address offset.
module spi_flash_trace_record_decoder
  import sftrd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sftrd_in_if.sink    in_rec,
  sftrd_out_if.source out_res,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  rec_t rec;
  job_t push_job;
  job_t q_job;
  res_t res;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  logic in_ready;
  logic out_valid;

  always_comb begin
    rec.record_id  = in_rec.record_id;
    rec.record_pos = in_rec.record_pos;
    rec.payload    = {in_rec.payload_5, in_rec.payload_4, in_rec.payload_3,
                      in_rec.payload_2, in_rec.payload_1, in_rec.payload_0};
  end

  assign in_rec.ready = in_ready;

  sftrd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_rec.valid),
    .in_ready (in_ready),
    .in_rec   (rec),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  sftrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  sftrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_res.ready),
    .out_res   (res)
  );

  assign out_res.valid          = out_valid;
  assign out_res.kind           = res.kind;
  assign out_res.command_number = res.command_number;
  assign out_res.opcode         = res.opcode;
  assign out_res.table_index    = res.table_index;
  assign out_res.elapsed_time   = res.elapsed_time;
  assign out_res.has_address    = res.has_address;
  assign out_res.byte_address   = res.byte_address;
  assign out_res.data_byte      = res.data_byte;
  assign out_res.column         = res.column;
  assign out_res.last           = res.last;

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue write while full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue read while empty");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule
